### rtl/core/hc3_pkg.sv
// shared types, constants and mod-26 helpers for the 3x3 hill cipher
package hc3_pkg;

   localparam int LETTER_W  = 5;
   localparam int ENTRIES   = 9;
   localparam int KEY_W     = LETTER_W * ENTRIES;
   localparam int ALPHA     = 26;
   localparam int PROD_W    = 2 * LETTER_W;
   localparam int WIDE_W    = 12;
   localparam int CSR_IDX_W = 1;

   localparam logic [KEY_W-1:0]     KEY_RESET = 45'd1099512676353;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 1'd1;

   // 650 = 25 * 26, keeps a cofactor non-negative without moving its residue
   localparam logic [WIDE_W-1:0] COF_BIAS = 12'd650;
   // ceil(2^16 / 26), exact quotient for any 12-bit dividend
   localparam logic [WIDE_W-1:0] RECIP_26 = 12'd2521;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [WIDE_W-1:0]   wide_type;
   typedef logic [PROD_W-1:0]   prod_type;
   typedef letter_type [ENTRIES-1:0] key_type;

   typedef struct packed {
      letter_type [2:0] letters;
      key_type          key;
      logic             bad;
   } block_type;

   typedef enum logic [2:0] {
      DRV_IDLE,
      DRV_COF,
      DRV_MOD,
      DRV_DSUM,
      DRV_DINV,
      DRV_APRD,
      DRV_AMOD
   } drv_state_type;

   // one compare and subtract, input below 32
   function automatic letter_type red26_f(input letter_type x);
      return (x >= LETTER_W'(ALPHA)) ? x - LETTER_W'(ALPHA) : x;
   endfunction

   // residue mod 26 by reciprocal multiply
   function automatic letter_type mod26_f(input wide_type x);
      logic [2*WIDE_W-1:0] prod;
      logic [7:0]          quot;
      wide_type            rem;
      prod = {{WIDE_W{1'b0}}, x} * {{WIDE_W{1'b0}}, RECIP_26};
      quot = prod[2*WIDE_W-1:16];
      rem  = x - WIDE_W'(quot) * WIDE_W'(ALPHA);
      return rem[LETTER_W-1:0];
   endfunction

   // multiplicative inverse mod 26, zero where none exists
   function automatic letter_type inv26_f(input letter_type d);
      letter_type r;
      case (d)
         5'd1:    r = 5'd1;
         5'd3:    r = 5'd9;
         5'd5:    r = 5'd21;
         5'd7:    r = 5'd15;
         5'd9:    r = 5'd3;
         5'd11:   r = 5'd19;
         5'd15:   r = 5'd7;
         5'd17:   r = 5'd23;
         5'd19:   r = 5'd11;
         5'd21:   r = 5'd5;
         5'd23:   r = 5'd17;
         5'd25:   r = 5'd25;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic det_bad_f(input letter_type d);
      return (d[0] == 1'b0) || (d == LETTER_W'(13));
   endfunction

endpackage

### rtl/core/hc3_inv_derive.sv
// sequencer that derives the inverse key and the invalid-key flag
module hc3_inv_derive
   import hc3_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   output key_type          inv_key,
   output logic             key_bad,
   output logic             busy
);

   drv_state_type state_ff, state_in;
   key_type       ent_ff, ent_in;
   wide_type      cof_ff [ENTRIES];
   wide_type      cof_in [ENTRIES];
   key_type       cofm_ff, cofm_in;
   wide_type      dsum_ff, dsum_in;
   letter_type    dinv_ff, dinv_in;
   logic          bad_stage_ff, bad_stage_in;
   prod_type      prd_ff [ENTRIES];
   prod_type      prd_in [ENTRIES];
   key_type       inv_ff, inv_in;
   logic          bad_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DRV_IDLE: if (start) state_in = DRV_COF;
         DRV_COF:  state_in = DRV_MOD;
         DRV_MOD:  state_in = DRV_DSUM;
         DRV_DSUM: state_in = DRV_DINV;
         DRV_DINV: state_in = DRV_APRD;
         DRV_APRD: state_in = DRV_AMOD;
         DRV_AMOD: state_in = DRV_IDLE;
         default:  state_in = DRV_IDLE;
      endcase
      // a fresh key write restarts the derivation from the new key
      if (start) state_in = DRV_COF;
   end

   // reduced entries and biased cofactors, cyclic index form
   always_comb begin
      int r1, r2, c1, c2;
      prod_type pa, pb;
      for (int k = 0; k < ENTRIES; k++) begin
         ent_in[k] = red26_f(key[k*LETTER_W +: LETTER_W]);
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            r1 = (r == 2) ? 0 : r + 1;
            r2 = (r == 0) ? 2 : r - 1;
            c1 = (c == 2) ? 0 : c + 1;
            c2 = (c == 0) ? 2 : c - 1;
            pa = PROD_W'(ent_in[r1*3+c1]) * PROD_W'(ent_in[r2*3+c2]);
            pb = PROD_W'(ent_in[r1*3+c2]) * PROD_W'(ent_in[r2*3+c1]);
            cof_in[r*3+c] = WIDE_W'(pa) + COF_BIAS - WIDE_W'(pb);
         end
      end
   end

   always_comb begin
      letter_type d;
      prod_type   p0, p1, p2;
      for (int k = 0; k < ENTRIES; k++) begin
         cofm_in[k] = mod26_f(cof_ff[k]);
      end
      p0 = PROD_W'(ent_ff[0]) * PROD_W'(cofm_ff[0]);
      p1 = PROD_W'(ent_ff[1]) * PROD_W'(cofm_ff[1]);
      p2 = PROD_W'(ent_ff[2]) * PROD_W'(cofm_ff[2]);
      dsum_in = WIDE_W'(p0) + WIDE_W'(p1) + WIDE_W'(p2);
      d = mod26_f(dsum_ff);
      dinv_in = inv26_f(d);
      bad_stage_in = det_bad_f(d);
      // inverse entry (i,j) takes the cofactor of (j,i)
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prd_in[i*3+j] = PROD_W'(cofm_ff[j*3+i]) * PROD_W'(dinv_ff);
         end
      end
      for (int k = 0; k < ENTRIES; k++) begin
         inv_in[k] = bad_stage_ff ? '0 : mod26_f(WIDE_W'(prd_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DRV_IDLE;
         inv_ff   <= key_type'(KEY_RESET);
         bad_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == DRV_AMOD) begin
            inv_ff <= inv_in;
            bad_ff <= bad_stage_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         DRV_COF: begin
            ent_ff <= ent_in;
            cof_ff <= cof_in;
         end
         DRV_MOD:  cofm_ff <= cofm_in;
         DRV_DSUM: dsum_ff <= dsum_in;
         DRV_DINV: begin
            dinv_ff      <= dinv_in;
            bad_stage_ff <= bad_stage_in;
         end
         DRV_APRD: prd_ff <= prd_in;
         default: ;
      endcase
   end

   assign inv_key = inv_ff;
   assign key_bad = bad_ff;
   assign busy    = (state_ff != DRV_IDLE);

endmodule

### rtl/core/hc3_gather.sv
// input side: collects three letters and captures the key in force
module hc3_gather
   import hc3_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  letter_type       req_letter_in,
   input  logic [KEY_W-1:0] key,
   input  key_type          inv_key,
   input  logic             mode,
   input  logic             key_bad,
   input  logic             derive_busy,
   input  logic             blk_take,
   output block_type        blk,
   output logic             blk_valid
);

   logic [1:0] fill_ff, fill_in;
   letter_type held_ff [2];
   block_type  blk_ff, blk_in;
   logic       blk_valid_ff, blk_valid_in;
   letter_type letter;
   logic       third;
   logic       accept;
   key_type    enc_key;

   assign letter    = red26_f(req_letter_in);
   assign third     = (fill_ff == 2'd2);
   assign req_stall = derive_busy || (third && blk_valid_ff && !blk_take);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         enc_key[k] = red26_f(key[k*LETTER_W +: LETTER_W]);
      end
      fill_in = fill_ff;
      if (accept) fill_in = third ? 2'd0 : fill_ff + 2'd1;
      blk_in.letters[0] = held_ff[0];
      blk_in.letters[1] = held_ff[1];
      blk_in.letters[2] = letter;
      blk_in.key        = mode ? inv_key : enc_key;
      blk_in.bad        = key_bad;
      blk_valid_in = blk_valid_ff;
      if (accept && third) blk_valid_in = 1'b1;
      else if (blk_take)   blk_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         blk_valid_ff <= 1'b0;
         held_ff[0]   <= '0;
         held_ff[1]   <= '0;
      end else begin
         fill_ff      <= fill_in;
         blk_valid_ff <= blk_valid_in;
         if (accept && !third) held_ff[fill_ff[0]] <= letter;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && third) blk_ff <= blk_in;
   end

   assign blk       = blk_ff;
   assign blk_valid = blk_valid_ff;

endmodule

### rtl/core/hc3_emit.sv
// matrix-vector product mod 26 and the three-beat result buffer
module hc3_emit
   import hc3_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  block_type  blk,
   input  logic       blk_valid,
   output logic       blk_take,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output letter_type rsp_letter_out,
   output logic       rsp_key_invalid,
   output logic       rsp_last
);

   wide_type   sum_ff [3];
   wide_type   sum_in [3];
   logic       sum_bad_ff;
   logic       sum_valid_ff, sum_valid_in;
   letter_type res_ff [3];
   logic       out_bad_ff;
   logic       out_valid_ff, out_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_accept;
   logic       out_free;
   logic       sum_move;

   assign rsp_accept = out_valid_ff && !rsp_stall;
   assign out_free   = !out_valid_ff || (rsp_accept && idx_ff == 2'd2);
   assign sum_move   = sum_valid_ff && out_free;
   assign blk_take   = blk_valid && (!sum_valid_ff || sum_move);

   // row dot products, one lane per result letter
   always_comb begin
      prod_type p0, p1, p2;
      for (int i = 0; i < 3; i++) begin
         p0 = PROD_W'(blk.key[i*3])   * PROD_W'(blk.letters[0]);
         p1 = PROD_W'(blk.key[i*3+1]) * PROD_W'(blk.letters[1]);
         p2 = PROD_W'(blk.key[i*3+2]) * PROD_W'(blk.letters[2]);
         sum_in[i] = WIDE_W'(p0) + WIDE_W'(p1) + WIDE_W'(p2);
      end
   end

   always_comb begin
      sum_valid_in = sum_valid_ff;
      if (blk_take)      sum_valid_in = 1'b1;
      else if (sum_move) sum_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;
      if (sum_move) begin
         out_valid_in = 1'b1;
         idx_in       = '0;
      end else if (rsp_accept) begin
         if (idx_ff == 2'd2) out_valid_in = 1'b0;
         else                idx_in       = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         sum_valid_ff <= sum_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (blk_take) begin
         sum_ff     <= sum_in;
         sum_bad_ff <= blk.bad;
      end
      if (sum_move) begin
         for (int i = 0; i < 3; i++) begin
            res_ff[i] <= mod26_f(sum_ff[i]);
         end
         out_bad_ff <= sum_bad_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_letter_out  = (idx_ff == 2'd0) ? res_ff[0] :
                            (idx_ff == 2'd1) ? res_ff[1] : res_ff[2];
   assign rsp_key_invalid = out_bad_ff;
   assign rsp_last        = (idx_ff == 2'd2);

endmodule

### rtl/core/hill_cipher_3x3.sv
// top level of the 3x3 hill cipher over the 26-letter alphabet
// a block is registered in the gather stage, its row sums in the emit stage,
//   and its mod-26 results in the buffer that sends out the three beats
// throughput: one letter in and one result out per cycle, unless stalled
// a key write stalls the request side while the inverse key and
//   the invalid-key flag are derived by a six-step sequencer
// reset (synchronous, active high): identity key, encrypt mode, empty block
module hill_cipher_3x3
   import hc3_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // register write port
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_write_data,
   // letter beats in
   input  logic                 req_valid,
   output logic                 req_stall,
   input  letter_type           req_letter_in,
   // result beats out
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output letter_type           rsp_letter_out,
   output logic                 rsp_key_invalid,
   output logic                 rsp_last
);

   // raw key as written; entries 26..31 are reduced where they are used
   logic [KEY_W-1:0] key_ff;
   logic             mode_ff;
   logic             key_write;

   key_type   inv_key;
   logic      key_bad;
   logic      derive_busy;
   block_type blk;
   logic      blk_valid;
   logic      blk_take;

   assign key_write = csr_write_en && (csr_index == CSR_KEY);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= KEY_RESET;
         mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_KEY:  key_ff  <= csr_write_data;
            CSR_MODE: mode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // inverse key: adjugate times inverse determinant, all zero for a bad key
   hc3_inv_derive u_derive (
      .clock   (clock),
      .reset   (reset),
      .start   (key_write),
      .key     (key_ff),
      .inv_key (inv_key),
      .key_bad (key_bad),
      .busy    (derive_busy)
   );

   // collects three letters, then captures letters, key in force and flag
   hc3_gather u_gather (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_letter_in (req_letter_in),
      .key           (key_ff),
      .inv_key       (inv_key),
      .mode          (mode_ff),
      .key_bad       (key_bad),
      .derive_busy   (derive_busy),
      .blk_take      (blk_take),
      .blk           (blk),
      .blk_valid     (blk_valid)
   );

   // dot products, mod 26, then three result beats from a holding buffer
   hc3_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .blk             (blk),
      .blk_valid       (blk_valid),
      .blk_take        (blk_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_letter_out  (rsp_letter_out),
      .rsp_key_invalid (rsp_key_invalid),
      .rsp_last        (rsp_last)
   );

endmodule

### rtl/core/hc3_checker.sv
// port-level checks for the 3x3 hill cipher, bound to the top level
module hc3_checker
   import hc3_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 csr_write_en,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input letter_type           rsp_letter_out,
   input logic                 rsp_key_invalid,
   input logic                 rsp_last
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_letter_out))
      else $error("stalled result beat changed");

   // the three beats of a block come out without a gap
   a_block_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("result block broken off before its last beat");

   // one key flag for the whole block
   a_flag_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> $stable(rsp_key_invalid))
      else $error("key flag changed inside a block");

   // a key write holds off new letters while the inverse is derived
   a_key_stall: assert property (@(posedge clock) disable iff (reset)
      csr_write_en && (csr_index == CSR_KEY) |=> req_stall)
      else $error("letter taken during inverse key derivation");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_letter_out < LETTER_W'(ALPHA)))
      else $error("result letter out of range");

endmodule

bind hill_cipher_3x3 hc3_checker u_checker (.*);

### verif/tb.sv
// self-checking testbench for the 3x3 hill cipher: directed and random letter beats
module tb
   import hc3_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // a run that is several times longer than the slowest correct one is hung
   localparam int CYCLE_LIMIT   = 200000;
   // settle margin after the last result, also covering the key sequencer
   localparam int SETTLE_CYCLES = 10;
   localparam int RANDOM_LETTERS = 350;

   // row-major 6 24 1 / 13 16 10 / 20 17 15, entry 0 in the low bits
   localparam logic [KEY_W-1:0] CLASSIC_KEY =
      {5'd15, 5'd17, 5'd20, 5'd10, 5'd16, 5'd13, 5'd1, 5'd24, 5'd6};

   typedef struct packed {
      letter_type letter_out;
      logic       key_invalid;
      logic       last;
   } cipher_result_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [KEY_W-1:0]     csr_write_data;
   logic                 req_valid;
   logic                 req_stall;
   letter_type           req_letter_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   letter_type           rsp_letter_out;
   logic                 rsp_key_invalid;
   logic                 rsp_last;

   hill_cipher_3x3 dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_letter_in   (req_letter_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_letter_out  (rsp_letter_out),
      .rsp_key_invalid (rsp_key_invalid),
      .rsp_last        (rsp_last)
   );

   // ---------------------------------------------------------------
   // shadow copy of the cipher state, updated on every accepted beat and register write
   // ---------------------------------------------------------------
   logic [KEY_W-1:0] shadow_key;
   logic [KEY_W-1:0] shadow_inv_key;
   logic             shadow_decrypt;
   letter_type       shadow_held [2];
   int unsigned      shadow_fill;

   // cipher letters still owed by the block, oldest first
   cipher_result_type pending_cipher_q [$];

   int unsigned error_count;
   int unsigned letter_beats;
   int unsigned result_beats;
   int unsigned csr_writes;
   int unsigned bad_key_blocks;
   int unsigned decrypt_blocks;
   int unsigned cycle_count;
   bit          burst_mode;   // when set neither side idles

   cipher_result_type got_beat;
   cipher_result_type want_beat;

   // ---------------------------------------------------------------
   // mod-26 arithmetic of the cipher, written out on plain integers
   // ---------------------------------------------------------------
   function automatic int mod26(input int x);
      return ((x % 26) + 26) % 26;
   endfunction

   // key entries of 26..31 count mod 26
   function automatic int key_entry(input logic [KEY_W-1:0] k, input int idx);
      return int'(k[5*idx +: 5]) % 26;
   endfunction

   // signed cofactor of (r,c) in the cyclic form, so no sign flip is needed
   function automatic int cofactor(input logic [KEY_W-1:0] k, input int r, input int c);
      int r1, r2, c1, c2;
      r1 = (r + 1) % 3;
      r2 = (r + 2) % 3;
      c1 = (c + 1) % 3;
      c2 = (c + 2) % 3;
      return key_entry(k, r1*3 + c1) * key_entry(k, r2*3 + c2)
           - key_entry(k, r1*3 + c2) * key_entry(k, r2*3 + c1);
   endfunction

   function automatic int det_mod26(input logic [KEY_W-1:0] k);
      int d;
      d = 0;
      for (int c = 0; c < 3; c++) d += key_entry(k, c) * cofactor(k, 0, c);
      return mod26(d);
   endfunction

   // determinant shares a factor with 26, so the key has no inverse
   function automatic bit key_is_singular(input logic [KEY_W-1:0] k);
      int d;
      d = det_mod26(k);
      return (d % 2 == 0) || (d % 13 == 0);
   endfunction

   // adjugate times inverse determinant; all zero for a singular key
   function automatic logic [KEY_W-1:0] inverse_key_of(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] inv;
      int d, dinv;
      inv = '0;
      if (key_is_singular(k)) return inv;
      d    = det_mod26(k);
      dinv = 0;
      for (int x = 1; x < 26; x++) if ((d * x) % 26 == 1) dinv = x;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            inv[5*(i*3 + j) +: 5] = 5'((mod26(cofactor(k, j, i)) * dinv) % 26);
      return inv;
   endfunction

   // one accepted letter: hold it, or on the third one queue three cipher letters
   task automatic hill_predict(input letter_type letter_in);
      int                blk [3];
      int                sum;
      bit                singular;
      logic [KEY_W-1:0]  mat;
      cipher_result_type r;
      if (shadow_fill < 2) begin
         shadow_held[shadow_fill] = 5'(int'(letter_in) % 26);
         shadow_fill++;
         return;
      end
      shadow_fill = 0;
      blk[0]   = shadow_held[0];
      blk[1]   = shadow_held[1];
      blk[2]   = int'(letter_in) % 26;
      singular = key_is_singular(shadow_key);
      mat      = shadow_decrypt ? shadow_inv_key : shadow_key;
      if (singular) bad_key_blocks++;
      if (shadow_decrypt) decrypt_blocks++;
      for (int i = 0; i < 3; i++) begin
         sum = 0;
         for (int j = 0; j < 3; j++) sum += key_entry(mat, i*3 + j) * blk[j];
         sum = sum % 26;
         // no inverse exists: decrypt gives letter 0 everywhere
         if (shadow_decrypt && singular) sum = 0;
         r.letter_out  = 5'(sum);
         r.key_invalid = singular;
         r.last        = (i == 2);
         pending_cipher_q.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------
   // clock, cycle limit
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d cipher letters still owed",
                  cycle_count, pending_cipher_q.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      return burst_mode ? 0 : $urandom_range(0, 4);
   endfunction

   // ---------------------------------------------------------------
   // result side: random stall per beat, and the field-by-field check
   // ---------------------------------------------------------------
   int unsigned rsp_stall_left;
   int unsigned rsp_gap;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall      <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         // a beat just left: draw how long to hold off the next one
         rsp_gap         = pick_gap();
         rsp_stall_left <= rsp_gap;
         rsp_stall      <= (rsp_gap != 0);
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_stall      <= (rsp_stall_left > 1);
      end else begin
         rsp_stall      <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         result_beats++;
         got_beat.letter_out  = rsp_letter_out;
         got_beat.key_invalid = rsp_key_invalid;
         got_beat.last        = rsp_last;
         if (pending_cipher_q.size() == 0) begin
            $error("result beat with nothing owed: letter_out %0d key_invalid %0b last %0b",
                   got_beat.letter_out, got_beat.key_invalid, got_beat.last);
            error_count++;
         end else begin
            want_beat = pending_cipher_q.pop_front();
            if (got_beat.letter_out !== want_beat.letter_out) begin
               $error("letter_out: expected %0d, got %0d",
                      want_beat.letter_out, got_beat.letter_out);
               error_count++;
            end
            if (got_beat.key_invalid !== want_beat.key_invalid) begin
               $error("key_invalid: expected %0b, got %0b",
                      want_beat.key_invalid, got_beat.key_invalid);
               error_count++;
            end
            if (got_beat.last !== want_beat.last) begin
               $error("last: expected %0b, got %0b", want_beat.last, got_beat.last);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // request side and register port
   // ---------------------------------------------------------------

   // one letter beat; valid stays high into the next call when no gap is drawn
   task automatic send_letter(input letter_type letter_in);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_letter_in <= letter_in;
      do @(posedge clock); while (req_stall);
      letter_beats++;
      hill_predict(letter_in);
   endtask

   // stop sending, let every owed letter arrive, then let the pipe settle
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_cipher_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register writes only go in with nothing in flight
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
      drain_block();
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      csr_writes++;
      if (idx == CSR_KEY) begin
         shadow_key     = data;
         shadow_inv_key = inverse_key_of(data);
      end else if (idx == CSR_MODE) begin
         shadow_decrypt = data[0];
      end
   endtask

   // mode write with random junk above bit 0, which must be ignored
   task automatic set_mode(input bit decrypt);
      logic [KEY_W-1:0] data;
      data    = KEY_W'({$urandom(), $urandom()});
      data[0] = decrypt;
      write_csr(CSR_MODE, data);
   endtask

   task automatic send_block(input int a, input int b, input int c);
      send_letter(5'(a));
      send_letter(5'(b));
      send_letter(5'(c));
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // identity key out of reset: letters pass through, out-of-range ones wrap
   task automatic test_reset_key();
      send_block(0, 25, 31);
      send_block(26, 1, 13);
   endtask

   // decrypt before any key write uses the reset inverse, also the identity
   task automatic test_reset_inverse();
      set_mode(1'b1);
      send_block(7, 24, 30);
   endtask

   // well-known invertible key, encrypt then decrypt its own output
   task automatic test_classic_key();
      write_csr(CSR_KEY, CLASSIC_KEY);
      set_mode(1'b0);
      send_block(0, 2, 19);
      set_mode(1'b1);
      send_block(15, 14, 7);
   endtask

   // every entry 31 (5 mod 26): determinant zero, flag set in both modes
   task automatic test_singular_key();
      write_csr(CSR_KEY, {KEY_W{1'b1}});
      set_mode(1'b0);
      send_block(25, 25, 25);
      set_mode(1'b1);
      send_block(3, 9, 31);
   endtask

   // registers rewritten with two letters held; the new key and mode apply
   task automatic test_write_mid_block();
      set_mode(1'b0);
      send_letter(5'd11);
      send_letter(5'd22);
      write_csr(CSR_KEY, CLASSIC_KEY);
      set_mode(1'b1);
      send_letter(5'd4);
   endtask

   // random phases: new key and mode each phase, mostly invertible keys
   task automatic test_random_phases();
      int               sent;
      int               phase;
      int               count;
      logic [KEY_W-1:0] k;
      int               pick;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_LETTERS) begin
         // first phases hit the extremes of the key register, then the reset key
         if (phase == 0) k = '0;
         else if (phase == 1) k = {KEY_W{1'b1}};
         else if (phase == 2) k = KEY_RESET;
         else begin
            k = KEY_W'({$urandom(), $urandom()});
            if ($urandom_range(0, 9) < 7) begin
               for (int t = 0; t < 64 && key_is_singular(k); t++)
                  k = KEY_W'({$urandom(), $urandom()});
            end
         end
         burst_mode = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 1) begin
            write_csr(CSR_KEY, k);
            set_mode(1'($urandom_range(0, 1)));
         end else begin
            set_mode(1'($urandom_range(0, 1)));
            write_csr(CSR_KEY, k);
         end
         // phase lengths need not be multiples of three, so blocks can span writes
         count = $urandom_range(20, 45);
         for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) send_letter(5'($urandom_range(26, 31)));
            else send_letter(5'($urandom_range(0, 25)));
         end
         sent += count;
         phase++;
      end
      burst_mode = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      reset          <= 1'b1;
      csr_write_en   <= 1'b0;
      csr_index      <= CSR_KEY;
      csr_write_data <= '0;
      req_valid      <= 1'b0;
      req_letter_in  <= '0;
      cycle_count    = 0;
      error_count    = 0;
      letter_beats   = 0;
      result_beats   = 0;
      csr_writes     = 0;
      bad_key_blocks = 0;
      decrypt_blocks = 0;
      burst_mode     = 1'b0;
      shadow_key     = KEY_RESET;
      shadow_inv_key = KEY_RESET;
      shadow_decrypt = 1'b0;
      shadow_held[0] = '0;
      shadow_held[1] = '0;
      shadow_fill    = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_key();
      test_reset_inverse();
      test_classic_key();
      test_singular_key();
      test_write_mid_block();
      test_random_phases();

      drain_block();

      $display("%0d letter beats in, %0d cipher letters out, %0d register writes",
               letter_beats, result_beats, csr_writes);
      $display("%0d blocks decrypted, %0d blocks under a singular key",
               decrypt_blocks, bad_key_blocks);
      if (error_count == 0 && pending_cipher_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/hc3_pkg.sv
rtl/core/hc3_inv_derive.sv
rtl/core/hc3_gather.sv
rtl/core/hc3_emit.sv
rtl/core/hill_cipher_3x3.sv
rtl/core/hc3_checker.sv
verif/tb.sv
